>>> rtl/sfi_pkg.sv
// shared types and constants for the stump forest inference block
package sfi_pkg;

    // request commands
    localparam logic CMD_TREE_WRITE = 1'b0;
    localparam logic CMD_FEATURE    = 1'b1;

    // configuration register indexes
    localparam logic CFG_REGRESSION_MODE = 1'b0;
    localparam logic CFG_STUMP_COUNT     = 1'b1;

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 7;

    // 0.5 in Q16.16
    localparam logic signed [VALUE_W-1:0] HALF_Q16 = 32'sh0000_8000;

    // one input request
    typedef struct packed {
        logic                      cmd;
        logic [5:0]                tree_slot;
        logic [4:0]                split_feature;
        logic signed [VALUE_W-1:0] split_threshold;
        logic signed [VALUE_W-1:0] left_leaf;
        logic signed [VALUE_W-1:0] right_leaf;
        logic signed [VALUE_W-1:0] feature_value;
        logic                      last;
    } t_req;

    // one prediction result
    typedef struct packed {
        logic                      predicted_class;
        logic signed [VALUE_W-1:0] predicted_value;
        logic [6:0]                vote_total;
    } t_rsp;

    // one stump table entry
    typedef struct packed {
        logic [4:0]                feature;
        logic signed [VALUE_W-1:0] threshold;
        logic signed [VALUE_W-1:0] left_leaf;
        logic signed [VALUE_W-1:0] right_leaf;
    } t_stump;

endpackage

>>> rtl/sfi_req_if.sv
// request channel interface: valid, ready and payload
interface sfi_req_if;
    logic          valid;
    logic          ready;
    sfi_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/sfi_rsp_if.sv
// result channel interface: valid, ready and payload
interface sfi_rsp_if;
    logic          valid;
    logic          ready;
    sfi_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/sfi_div.sv
// iterative restoring divider, one quotient bit per cycle
module sfi_div #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    n_trial;
    logic                  n_ge;
    logic [DIVISOR_W:0]    n_diff;

    // trial subtract of the shifted remainder
    always_comb begin
        n_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_diff  = n_trial - {1'b0, r_div};
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DIVISOR_W-1:0] : n_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/stump_forest_inference.sv
// top level: stump table, sample buffer, stump walk sequencer and result register
// tree writes and plain feature loads leave the block idle and ready for the next request
// a last feature starts a walk over the stumps, each taken in table read, sample read and accumulate states
// classification result is registered in the done state once the result register is free (count clamped)
// regression adds divider load and wait states; the divider works through all 32+clog2(MAX_TREES+1) sum bits
// synchronous active-low reset clears control, config and sample position; tables are not cleared
module stump_forest_inference #(
    parameter int MAX_TREES    = 64,
    parameter int MAX_FEATURES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic [sfi_pkg::CFG_W-1:0]   i_cfg_wdata,
    sfi_req_if.sink                     i_req,
    sfi_rsp_if.source                   o_rsp
);

    localparam int TW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int CW = $clog2(MAX_TREES + 1);
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PW = $clog2(MAX_FEATURES + 1);
    localparam int VW = sfi_pkg::VALUE_W;
    localparam int SW = VW + CW;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_FETCH    = 7'b0000010,
        S_LOOKUP   = 7'b0000100,
        S_ACCUM    = 7'b0001000,
        S_DIV_LOAD = 7'b0010000,
        S_DIV_WAIT = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state                    r_state;
    logic                      r_regression_mode;
    logic [sfi_pkg::CFG_W-1:0] r_stump_count;
    logic [PW-1:0]             r_pos;
    logic [TW-1:0]             r_idx;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_votes;
    logic signed [SW-1:0]      r_sum;
    sfi_pkg::t_stump           r_stump;
    logic signed [VW-1:0]      r_xval;
    logic                      r_xin;
    logic                      r_neg;
    logic                      r_rsp_valid;
    sfi_pkg::t_rsp             r_rsp;

    sfi_pkg::t_stump           r_stump_mem [MAX_TREES];
    logic signed [VW-1:0]      r_sample_mem [MAX_FEATURES];

    logic                      n_accept;
    logic                      n_tree_wr;
    logic                      n_feat_wr;
    logic [CW-1:0]             n_count;
    logic signed [VW-1:0]      n_x;
    logic signed [VW-1:0]      n_leaf;
    logic                      n_vote;
    logic                      n_last_tree;
    logic [SW-1:0]             n_abs_sum;
    logic                      n_div_start;
    logic                      n_div_done;
    logic [SW-1:0]             n_quotient;
    logic [VW-1:0]             n_q32;
    logic                      n_rsp_free;

    // handshake decode
    always_comb begin
        n_accept  = i_req.valid && (r_state == S_IDLE);
        n_tree_wr = n_accept && (i_req.payload.cmd == sfi_pkg::CMD_TREE_WRITE)
                    && (int'(i_req.payload.tree_slot) < MAX_TREES);
        n_feat_wr = n_accept && (i_req.payload.cmd == sfi_pkg::CMD_FEATURE)
                    && (int'(r_pos) < MAX_FEATURES);
    end

    assign i_req.ready = (r_state == S_IDLE);

    // clamp the configured stump count
    always_comb begin
        if (r_stump_count == '0) begin
            n_count = CW'(1);
        end else if (int'(r_stump_count) > MAX_TREES) begin
            n_count = CW'(MAX_TREES);
        end else begin
            n_count = CW'(r_stump_count);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regression_mode <= 1'b0;
            r_stump_count     <= sfi_pkg::CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sfi_pkg::CFG_REGRESSION_MODE: r_regression_mode <= i_cfg_wdata[0];
                sfi_pkg::CFG_STUMP_COUNT:     r_stump_count     <= i_cfg_wdata;
                default:                      r_stump_count     <= r_stump_count;
            endcase
        end
    end

    // stump table: write on tree request, registered read at walk index
    always_ff @(posedge i_clk) begin
        if (n_tree_wr) begin
            r_stump_mem[TW'(i_req.payload.tree_slot)] <= '{
                feature:    i_req.payload.split_feature,
                threshold:  i_req.payload.split_threshold,
                left_leaf:  i_req.payload.left_leaf,
                right_leaf: i_req.payload.right_leaf
            };
        end
        r_stump <= r_stump_mem[r_idx];
    end

    // sample buffer: append on feature request, registered read at split feature
    always_ff @(posedge i_clk) begin
        if (n_feat_wr) begin
            r_sample_mem[r_pos[FW-1:0]] <= i_req.payload.feature_value;
        end
        r_xval <= r_sample_mem[FW'(r_stump.feature)];
        r_xin  <= int'(r_stump.feature) < MAX_FEATURES;
    end

    // leaf select and vote for the current stump, plus walk, divider and result helpers
    always_comb begin
        n_x         = r_xin ? r_xval : '0;
        n_leaf      = (n_x <= r_stump.threshold) ? r_stump.left_leaf : r_stump.right_leaf;
        n_vote      = n_leaf >= sfi_pkg::HALF_Q16;
        n_last_tree = (CW'(r_idx) + CW'(1)) == r_count;
        n_abs_sum   = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
        n_div_start = (r_state == S_DIV_LOAD);
        n_q32       = n_quotient[VW-1:0];
        n_rsp_free  = !r_rsp_valid || o_rsp.ready;
    end

    // divider for the regression mean
    sfi_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_abs_sum),
        .i_divisor  (r_count),
        .o_done     (n_div_done),
        .o_quotient (n_quotient)
    );

    // walk sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept && (i_req.payload.cmd == sfi_pkg::CMD_FEATURE)) begin
                        if (i_req.payload.last) begin
                            r_pos   <= '0;
                            r_idx   <= '0;
                            r_state <= S_FETCH;
                        end else if (n_feat_wr) begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end
                end
                S_FETCH:  r_state <= S_LOOKUP;
                S_LOOKUP: r_state <= S_ACCUM;
                S_ACCUM: begin
                    if (n_last_tree) begin
                        r_state <= r_regression_mode ? S_DIV_LOAD : S_DONE;
                    end else begin
                        r_idx   <= r_idx + TW'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_DIV_LOAD: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (n_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_rsp_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && n_accept) begin
            r_sum   <= '0;
            r_votes <= '0;
            r_count <= n_count;
        end else if (r_state == S_ACCUM) begin
            r_sum   <= r_sum + {{CW{n_leaf[VW-1]}}, n_leaf};
            r_votes <= r_votes + CW'(n_vote);
        end
        if (r_state == S_DIV_LOAD) begin
            r_neg <= r_sum[SW-1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if ((r_state == S_DONE) && n_rsp_free) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && n_rsp_free) begin
            r_rsp.vote_total <= 7'(r_votes);
            if (r_regression_mode) begin
                r_rsp.predicted_class <= 1'b0;
                r_rsp.predicted_value <= r_neg ? VW'(-n_q32) : n_q32;
            end else begin
                r_rsp.predicted_class <= ({1'b0, r_votes} << 1) >= {1'b0, r_count};
                r_rsp.predicted_value <= '0;
            end
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

>>> rtl/sfi_checker.sv
// port-level checks for the stump forest inference block, bound to the top level
module sfi_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  logic          i_req_cmd,
    input  logic          i_req_last,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  sfi_pkg::t_rsp i_rsp_payload
);

    // a pending result stays offered until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_payload))
        else $error("result payload changed while stalled");

    // a last feature request starts a walk, so the next request must wait
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_cmd == sfi_pkg::CMD_FEATURE) && i_req_last
        |=> !i_req_ready)
        else $error("request taken during a prediction walk");

    // no result comes out of reset
    a_rsp_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

    // a class vote and a regression value never appear together
    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_payload.predicted_class |-> i_rsp_payload.predicted_value == '0)
        else $error("class and value both set");

endmodule

bind stump_forest_inference sfi_checker u_sfi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_cmd     (i_req.payload.cmd),
    .i_req_last    (i_req.payload.last),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);

>>> bench/tb_top.sv
// self-checking testbench for the stump forest inference block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = 64;
    localparam int NUM_ELEMENTS = 32;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES  = 300;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        cfg_wr_en;
    logic                        cfg_index;
    logic [sfi_pkg::CFG_W-1:0]   cfg_wdata;

    sfi_req_if req_ch ();
    sfi_rsp_if rsp_ch ();

    stump_forest_inference dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // shadow copy of the block state
    sfi_pkg::t_stump             stump_shadow [NUM_SLOTS];
    logic signed [31:0]          sample_shadow [NUM_ELEMENTS];
    int                          sample_fill;
    logic                        regression_shadow;
    logic [sfi_pkg::CFG_W-1:0]   stump_count_shadow;

    sfi_pkg::t_rsp expected_predictions [$];
    int   fail_count = 0;
    int   quiet_cycles;
    bit   req_gap_en;
    bit   rsp_stall_en;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor: update shadow state and queue the prediction a last element causes
    function automatic void forest_accept(sfi_pkg::t_req r);
        longint             sum;
        longint             leaf;
        longint             n;
        int                 votes;
        logic signed [31:0] x;
        sfi_pkg::t_rsp      exp;
        if (r.cmd == sfi_pkg::CMD_TREE_WRITE) begin
            stump_shadow[r.tree_slot] = '{feature: r.split_feature,
                                          threshold: r.split_threshold,
                                          left_leaf: r.left_leaf,
                                          right_leaf: r.right_leaf};
            return;
        end
        if (sample_fill < NUM_ELEMENTS) begin
            sample_shadow[sample_fill] = r.feature_value;
            sample_fill++;
        end
        if (!r.last)
            return;
        sample_fill = 0;
        n = longint'(stump_count_shadow);
        if (n == 0)
            n = 1;
        if (n > NUM_SLOTS)
            n = NUM_SLOTS;
        sum = 0;
        votes = 0;
        for (int t = 0; t < n; t++) begin
            x = sample_shadow[stump_shadow[t].feature];
            // at most threshold goes left
            if ($signed(x) <= $signed(stump_shadow[t].threshold))
                leaf = longint'(stump_shadow[t].left_leaf);
            else
                leaf = longint'(stump_shadow[t].right_leaf);
            if (leaf >= longint'(sfi_pkg::HALF_Q16))
                votes++;
            sum += leaf;
        end
        if (regression_shadow) begin
            exp.predicted_class = 1'b0;
            exp.predicted_value = 32'(sum / n);
        end else begin
            exp.predicted_class = (votes * 2 >= n);
            exp.predicted_value = '0;
        end
        exp.vote_total = 7'(votes);
        expected_predictions.push_back(exp);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        sfi_pkg::t_rsp exp;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_predictions.size() == 0) begin
                $error("unexpected prediction: class %0d value %0d votes %0d",
                       rsp_ch.payload.predicted_class, rsp_ch.payload.predicted_value,
                       rsp_ch.payload.vote_total);
                fail_count++;
            end else begin
                exp = expected_predictions.pop_front();
                if (rsp_ch.payload.predicted_class !== exp.predicted_class) begin
                    $error("predicted_class: expected %0d, got %0d",
                           exp.predicted_class, rsp_ch.payload.predicted_class);
                    fail_count++;
                end
                if (rsp_ch.payload.predicted_value !== exp.predicted_value) begin
                    $error("predicted_value: expected %0d, got %0d",
                           exp.predicted_value, rsp_ch.payload.predicted_value);
                    fail_count++;
                end
                if (rsp_ch.payload.vote_total !== exp.vote_total) begin
                    $error("vote_total: expected %0d, got %0d",
                           exp.vote_total, rsp_ch.payload.vote_total);
                    fail_count++;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        rsp_ch.ready <= rsp_stall_en ? ($urandom_range(99) >= 15) : 1'b1;
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // send one request, with an optional gap before it
    task automatic send_req(sfi_pkg::t_req r);
        if (req_gap_en && $urandom_range(99) < 15) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 30);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        forest_accept(r);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(sfi_pkg::HALF_Q16) + 32'($urandom_range(0, 4)) - 32'd2;
            3: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic sfi_pkg::t_req tree_req(logic [5:0] slot, logic [4:0] feat,
                                               logic [31:0] thr, logic [31:0] lft,
                                               logic [31:0] rgt);
        sfi_pkg::t_req r;
        r = '0;
        r.cmd = sfi_pkg::CMD_TREE_WRITE;
        r.tree_slot = slot;
        r.split_feature = feat;
        r.split_threshold = thr;
        r.left_leaf = lft;
        r.right_leaf = rgt;
        r.feature_value = $urandom;
        r.last = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic sfi_pkg::t_req feature_req(logic [31:0] val, logic is_last);
        sfi_pkg::t_req r;
        r = '0;
        r.cmd = sfi_pkg::CMD_FEATURE;
        r.tree_slot = 6'($urandom);
        r.split_feature = 5'($urandom);
        r.split_threshold = $urandom;
        r.left_leaf = $urandom;
        r.right_leaf = $urandom;
        r.feature_value = val;
        r.last = is_last;
        return r;
    endfunction

    // stop sending, wait for all predictions and let the block settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_predictions.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers back to back
    task automatic set_config(logic mode, logic [sfi_pkg::CFG_W-1:0] count);
        cfg_wr_en <= 1'b1;
        cfg_index <= sfi_pkg::CFG_REGRESSION_MODE;
        cfg_wdata <= sfi_pkg::CFG_W'(mode);
        @(posedge i_clk);
        regression_shadow = mode;
        cfg_index <= sfi_pkg::CFG_STUMP_COUNT;
        cfg_wdata <= count;
        @(posedge i_clk);
        stump_count_shadow = count;
        cfg_wr_en <= 1'b0;
    endtask

    // fill every stump slot, extremes in the first few
    task automatic test_table_fill();
        send_req(tree_req(6'd0, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_req(tree_req(6'd1, 5'd31, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_req(tree_req(6'd2, 5'd2, 32'h0, 32'(sfi_pkg::HALF_Q16),
                          32'(sfi_pkg::HALF_Q16) - 32'd1));
        for (int s = 3; s < NUM_SLOTS; s++)
            send_req(tree_req(6'(s), 5'($urandom), pick_value(), pick_value(), pick_value()));
    endtask

    // reset configuration and a sample longer than the buffer
    task automatic test_sample_overflow();
        logic [31:0] val;
        for (int i = 0; i < NUM_ELEMENTS + 2; i++) begin
            case (i)
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                2: val = 32'h0;
                default: val = pick_value();
            endcase
            send_req(feature_req(val, i == NUM_ELEMENTS + 1));
        end
    endtask

    // stump count of zero, above the table size and at the table size
    task automatic test_count_limits();
        wait_idle();
        set_config(1'b0, 7'd0);
        send_req(feature_req(pick_value(), 1'b1));
        wait_idle();
        set_config(1'b1, 7'd127);
        send_req(feature_req(pick_value(), 1'b0));
        send_req(feature_req(pick_value(), 1'b1));
        wait_idle();
        set_config(1'b0, 7'd64);
        send_req(feature_req(pick_value(), 1'b1));
    endtask

    // vote threshold, ties, equal compare and truncated mean
    task automatic test_vote_boundary();
        wait_idle();
        set_config(1'b0, 7'd2);
        send_req(tree_req(6'd0, 5'd0, 32'd5, 32'(sfi_pkg::HALF_Q16),
                          32'(sfi_pkg::HALF_Q16) - 32'd1));
        send_req(tree_req(6'd1, 5'd1, -32'sd5, 32'(sfi_pkg::HALF_Q16) - 32'd1,
                          32'(sfi_pkg::HALF_Q16)));
        send_req(feature_req(32'd5, 1'b0));
        send_req(feature_req(-32'sd4, 1'b1));
        send_req(feature_req(32'd6, 1'b0));
        send_req(feature_req(-32'sd4, 1'b1));
        send_req(feature_req(32'd6, 1'b0));
        send_req(feature_req(-32'sd5, 1'b1));
        wait_idle();
        set_config(1'b1, 7'd2);
        send_req(tree_req(6'd0, 5'd0, 32'h7FFF_FFFF, -32'sd3, 32'd0));
        send_req(tree_req(6'd1, 5'd1, 32'h7FFF_FFFF, 32'd0, 32'd0));
        send_req(feature_req(32'd1, 1'b1));
        send_req(tree_req(6'd0, 5'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
        send_req(tree_req(6'd1, 5'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
        send_req(feature_req(32'd1, 1'b1));
        send_req(tree_req(6'd0, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        send_req(tree_req(6'd1, 5'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        send_req(feature_req(32'd1, 1'b1));
    endtask

    // random samples and table updates over several configurations
    task automatic test_random();
        int                          sent;
        int                          len;
        logic [sfi_pkg::CFG_W-1:0]   count;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: count = 7'd1;
                1: count = 7'd64;
                4: count = 7'd100;
                default: count = 7'($urandom_range(1, 16));
            endcase
            wait_idle();
            set_config(phase[0], count);
            // one phase runs with no idling on either side
            req_gap_en   = (phase != 3);
            rsp_stall_en = (phase != 3);
            sent = 0;
            while (sent < 50) begin
                if ($urandom_range(99) < 20) begin
                    send_req(tree_req(6'($urandom), 5'($urandom), pick_value(), pick_value(),
                                      pick_value()));
                    sent++;
                end else begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        // stray table update in the middle of a sample
                        if ($urandom_range(99) < 5) begin
                            send_req(tree_req(6'($urandom), 5'($urandom), pick_value(),
                                              pick_value(), pick_value()));
                            sent++;
                        end
                        send_req(feature_req(pick_value(), i == len - 1));
                        sent++;
                    end
                end
            end
        end
        req_gap_en   = 1'b1;
        rsp_stall_en = 1'b1;
    endtask

    // test sequence
    initial begin
        sample_fill        = 0;
        regression_shadow  = 1'b0;
        stump_count_shadow = 7'd1;
        req_gap_en         = 1'b1;
        rsp_stall_en       = 1'b1;
        i_rst_n        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= sfi_pkg::CFG_REGRESSION_MODE;
        cfg_wdata      <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_fill();
        test_sample_overflow();
        test_count_limits();
        test_vote_boundary();
        test_random();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
